[hdl/oim_pkg.sv]
`timescale 1ns / 1ps

package oim_pkg;

	localparam int unsigned DIST_W   = 10;
	localparam int unsigned PERIOD_W = 16;
	localparam int unsigned TIME_W   = 32;
	localparam int unsigned SPEED_W  = 8;
	localparam int unsigned MSPEED_W = 7;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 2'd1;

	localparam logic [DIST_W-1:0]   THRESHOLD_RESET = 10'd20;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET    = 16'd150;
	localparam logic [DIST_W-1:0]   DISTANCE_RESET  = 10'd999;
	localparam logic [SPEED_W-1:0]  SPEED_MAX       = 8'd100;

	typedef enum logic [2:0] {
		ST_INIT     = 3'd0,
		ST_STOPPED  = 3'd1,
		ST_MANUAL   = 3'd2,
		ST_OBSTACLE = 3'd3,
		ST_FAULT    = 3'd4
	} car_state_t;

	typedef enum logic [2:0] {
		CMD_NONE  = 3'd0,
		CMD_STOP  = 3'd1,
		CMD_FWD   = 3'd2,
		CMD_BACK  = 3'd3,
		CMD_LEFT  = 3'd4,
		CMD_RIGHT = 3'd5
	} motor_cmd_t;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_MOVE  = 2'd1,
		OP_STOP  = 2'd2,
		OP_RESET = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		DIR_FWD   = 2'd0,
		DIR_BACK  = 2'd1,
		DIR_LEFT  = 2'd2,
		DIR_RIGHT = 2'd3
	} dir_t;

	typedef struct packed {
		op_t                op;
		logic [TIME_W-1:0]  now;
		dir_t               dir;
		logic [SPEED_W-1:0] speed;
		logic [DIST_W-1:0]  range_cm;
		logic               ok;
	} item_t;

	typedef struct packed {
		car_state_t        mode;
		logic [DIST_W-1:0] range_cm;
		logic              good;
		logic [TIME_W-1:0] last_time;
	} vstate_t;

	typedef struct packed {
		car_state_t          state;
		motor_cmd_t          cmd;
		logic [MSPEED_W-1:0] speed;
		logic                acc;
		logic                meas;
	} result_t;

	typedef struct packed {
		logic [DIST_W-1:0]   threshold;
		logic [PERIOD_W-1:0] period;
	} cfg_t;

endpackage

[hdl/obstacle_interlock_motion_fsm.sv]
`timescale 1ns / 1ps
// Safety interlock for a two-motor vehicle.
// Input channel (in_valid / in_stall): one beat per operation - tick, move,
// stop or reset - with its time stamp, direction, speed and distance reading.
// Output channel (out_valid / out_stall): exactly one result beat per input
// beat, in order: state after the operation, motor command, motor speed,
// move accepted and reading taken.
// Configuration channel (cfg_valid / cfg_ready, always ready): index 0 sets
// the obstacle threshold, index 1 the measure period; other indices are
// ignored. Write only while no operation is in flight.
// A result passes through two registers - the input register, then the result
// register. Throughput is one beat per cycle while the output is not stalled,
// set by the single decision step between those two registers.
// A stalled result holds; one further input beat is taken into an empty input
// register meanwhile, after which in_stall rises until the result drains.
// Reset empties both registers, restores the configuration defaults and puts
// the vehicle in stopped with a clear 999 cm reading and a good sensor.
module obstacle_interlock_motion_fsm (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     operation,
	input  logic [31:0]                    now_ms,
	input  logic [1:0]                     direction,
	input  logic [7:0]                     speed_percent,
	input  logic [9:0]                     distance_cm,
	input  logic                           reading_ok,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [2:0]                     car_state,
	output logic [2:0]                     motor_command,
	output logic [6:0]                     motor_speed,
	output logic                           accepted,
	output logic                           measured,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [oim_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [oim_pkg::CFG_DATA_W-1:0] cfg_data
);
	import oim_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_s2;
	logic    valid_s2;
	vstate_t st_q;
	vstate_t st_next;
	result_t res;
	logic    advance;

	oim_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	oim_step u_step (
		.item    (item_s1),
		.st      (st_q),
		.cfg     (cfg),
		.st_next (st_next),
		.res     (res)
	);

	assign advance  = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1.op       <= op_t'(operation);
			item_s1.now      <= now_ms;
			item_s1.dir      <= dir_t'(direction);
			item_s1.speed    <= speed_percent;
			item_s1.range_cm <= distance_cm;
			item_s1.ok       <= reading_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2          <= 1'b0;
			st_q.mode         <= ST_STOPPED;
			st_q.range_cm     <= DISTANCE_RESET;
			st_q.good         <= 1'b1;
			st_q.last_time    <= '0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				st_q <= st_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_s2 <= res;
		end
	end

	assign out_valid     = valid_s2;
	assign car_state     = res_s2.state;
	assign motor_command = res_s2.cmd;
	assign motor_speed   = res_s2.speed;
	assign accepted      = res_s2.acc;
	assign measured      = res_s2.meas;

endmodule

[hdl/oim_cfg_regs.sv]
`timescale 1ns / 1ps

module oim_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [oim_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [oim_pkg::CFG_DATA_W-1:0] cfg_data,
	output oim_pkg::cfg_t                  cfg
);
	import oim_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold <= THRESHOLD_RESET;
			cfg_q.period    <= PERIOD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_THRESHOLD: cfg_q.threshold <= cfg_data[DIST_W-1:0];
				CFG_PERIOD:    cfg_q.period    <= cfg_data[PERIOD_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

[hdl/oim_step.sv]
`timescale 1ns / 1ps

module oim_step (
	input  oim_pkg::item_t   item,
	input  oim_pkg::vstate_t st,
	input  oim_pkg::cfg_t    cfg,
	output oim_pkg::vstate_t st_next,
	output oim_pkg::result_t res
);
	import oim_pkg::*;

	logic [TIME_W-1:0] elapsed;
	logic              tick_due;
	logic              read_near;
	logic              speed_bad;
	logic              fwd_blocked;
	motor_cmd_t        drive_cmd;

	assign elapsed     = item.now - st.last_time;
	assign tick_due    = elapsed >= {{(TIME_W-PERIOD_W){1'b0}}, cfg.period};
	assign read_near   = item.range_cm < cfg.threshold;
	assign speed_bad   = item.speed > SPEED_MAX;
	assign fwd_blocked = (item.dir == DIR_FWD) && !(st.good && (st.range_cm >= cfg.threshold));

	always_comb begin
		case (item.dir)
			DIR_FWD:   drive_cmd = CMD_FWD;
			DIR_BACK:  drive_cmd = CMD_BACK;
			DIR_LEFT:  drive_cmd = CMD_LEFT;
			DIR_RIGHT: drive_cmd = CMD_RIGHT;
			default:   drive_cmd = CMD_NONE;
		endcase
	end

	// next state
	always_comb begin
		st_next = st;
		case (item.op)
			OP_TICK: begin
				if (tick_due) begin
					st_next.last_time = item.now;
					st_next.good      = item.ok;
					if (!item.ok) begin
						st_next.mode = ST_FAULT;
					end else begin
						st_next.range_cm = item.range_cm;
						if (read_near && (st.mode == ST_MANUAL)) begin
							st_next.mode = ST_OBSTACLE;
						end
					end
				end
			end
			OP_MOVE: begin
				if (!speed_bad && (st.mode != ST_FAULT)) begin
					st_next.mode = fwd_blocked ? ST_OBSTACLE : ST_MANUAL;
				end
			end
			OP_STOP: begin
				if (st.mode != ST_FAULT) begin
					st_next.mode = ST_STOPPED;
				end
			end
			OP_RESET: begin
				st_next.good = item.ok;
				if (!item.ok) begin
					st_next.mode = ST_FAULT;
				end else begin
					st_next.range_cm = item.range_cm;
					st_next.mode     = read_near ? ST_OBSTACLE : ST_STOPPED;
				end
			end
			default: ;
		endcase
	end

	// result
	always_comb begin
		res       = '0;
		res.state = st_next.mode;
		res.cmd   = CMD_NONE;
		case (item.op)
			OP_TICK: begin
				res.meas = tick_due;
				if (tick_due && (!item.ok || read_near)) begin
					res.cmd = CMD_STOP;
				end
			end
			OP_MOVE: begin
				if (!speed_bad) begin
					if ((st.mode == ST_FAULT) || fwd_blocked) begin
						res.cmd = CMD_STOP;
					end else begin
						res.cmd   = drive_cmd;
						res.speed = item.speed[MSPEED_W-1:0];
						res.acc   = 1'b1;
					end
				end
			end
			OP_STOP: begin
				res.cmd = CMD_STOP;
			end
			OP_RESET: begin
				res.cmd  = CMD_STOP;
				res.meas = 1'b1;
			end
			default: ;
		endcase
	end

endmodule

[hdl/oim_checker.sv]
`timescale 1ns / 1ps

module oim_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [2:0] car_state,
	input logic [2:0] motor_command,
	input logic [6:0] motor_speed,
	input logic       accepted,
	input logic       measured
);
	import oim_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(car_state) &&
		$stable(motor_command) && $stable(motor_speed) && $stable(accepted) &&
		$stable(measured))
		else $error("stalled result beat changed");

	a_accept_drives: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && accepted |-> motor_command != CMD_NONE &&
		motor_command != CMD_STOP && car_state == ST_MANUAL)
		else $error("accepted move without drive in manual");

	a_speed_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !accepted |-> motor_speed == '0)
		else $error("speed shown without accepted move");

	a_move_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && accepted |-> !measured)
		else $error("move beat flagged a reading");

endmodule

bind obstacle_interlock_motion_fsm oim_checker u_oim_checker (.*);
